/* src/ppndc_pkg.sv */
// shared types and constants for the perspective projection block
`default_nettype none
package ppndc_pkg;

  localparam int unsigned COEF_FRAC = 24;
  localparam int unsigned NUM_COEF  = 6;
  localparam int unsigned DEN_W     = 48;
  localparam int unsigned MAG_W     = 64;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = 2;
  localparam int unsigned Q_CNT_W   = 3;
  localparam int unsigned DIV_STEPS = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_SCALE     = 3'd0,
    REG_X_OFFSET    = 3'd1,
    REG_Y_SCALE     = 3'd2,
    REG_Y_OFFSET    = 3'd3,
    REG_DEPTH_SCALE = 3'd4,
    REG_DEPTH_BIAS  = 3'd5
  } reg_idx_t;

  typedef logic [NUM_COEF-1:0][31:0] coef_t;

  // one classified item: numerator magnitudes, result signs, divisor
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [DEN_W-1:0]      den;
    logic                  w_zero;
  } entry_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one lane of the division pipeline
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [31:0]      lo;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       neg;
    logic             w_zero;
    logic [DEN_W-1:0] den;
    lane_t [2:0]      lane;
  } div_stage_t;

endpackage
`default_nettype wire

/* src/ppndc_front.sv */
// front part: matrix products, clip sums, sign and divisor set-up
`default_nettype none
module ppndc_front #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [31:0]             px,
  input  wire [31:0]             py,
  input  wire [31:0]             pz,
  input  ppndc_pkg::coef_t       coef,
  input  ppndc_pkg::q_stat_t     qstat,
  output logic                   push,
  output ppndc_pkg::entry_t      push_data
);

  localparam int unsigned DEN_SH = ppndc_pkg::COEF_FRAC - COORD_FRAC_BITS;

  logic s1_v_r, s2_v_r, fe;
  logic signed [63:0] p_xs_r, p_xo_r, p_ys_r, p_yo_r, p_zs_r, bias_r;
  logic [31:0] z1_r;
  ppndc_pkg::entry_t s2_r, s2_nxt;
  logic signed [64:0] sx, sy, sz;
  logic [31:0] zabs;
  logic w_neg;

  // whole front advances unless a finished item cannot enter the queue
  assign fe       = !s2_v_r || !qstat.full;
  assign in_ready = fe;
  assign push     = s2_v_r && !qstat.full;
  assign push_data = s2_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (fe) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (fe) begin
      p_xs_r <= $signed(coef[ppndc_pkg::REG_X_SCALE]) * $signed(px);
      p_xo_r <= $signed(coef[ppndc_pkg::REG_X_OFFSET]) * $signed(pz);
      p_ys_r <= $signed(coef[ppndc_pkg::REG_Y_SCALE]) * $signed(py);
      p_yo_r <= $signed(coef[ppndc_pkg::REG_Y_OFFSET]) * $signed(pz);
      p_zs_r <= $signed(coef[ppndc_pkg::REG_DEPTH_SCALE]) * $signed(pz);
      bias_r <= $signed({{32{coef[ppndc_pkg::REG_DEPTH_BIAS][31]}},
                         coef[ppndc_pkg::REG_DEPTH_BIAS]}) <<< COORD_FRAC_BITS;
      z1_r   <= pz;
    end
  end

  // stage 2: sums, magnitudes and result signs
  always_comb begin
    sx    = 65'(p_xs_r) + 65'(p_xo_r);
    sy    = 65'(p_ys_r) + 65'(p_yo_r);
    sz    = 65'(p_zs_r) + 65'(bias_r);
    w_neg = !z1_r[31] && (z1_r != 32'd0);
    zabs  = z1_r[31] ? (32'd0 - z1_r) : z1_r;
    s2_nxt.mag[0] = sx[64] ? 64'(-sx) : sx[63:0];
    s2_nxt.mag[1] = sy[64] ? 64'(-sy) : sy[63:0];
    s2_nxt.mag[2] = sz[64] ? 64'(-sz) : sz[63:0];
    s2_nxt.neg    = {sz[64] ^ w_neg, sy[64] ^ w_neg, sx[64] ^ w_neg};
    s2_nxt.den    = ppndc_pkg::DEN_W'(zabs) << DEN_SH;
    s2_nxt.w_zero = (z1_r == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (fe) s2_r <= s2_nxt;
  end

endmodule
`default_nettype wire

/* src/ppndc_queue.sv */
// short queue between front and back parts
`default_nettype none
module ppndc_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  ppndc_pkg::entry_t   push_data,
  input  wire                 pop,
  output ppndc_pkg::entry_t   head,
  output ppndc_pkg::q_stat_t  qstat
);

  ppndc_pkg::entry_t mem_r [ppndc_pkg::Q_DEPTH];
  logic [ppndc_pkg::Q_PTR_W-1:0] wr_r, rd_r;
  logic [ppndc_pkg::Q_CNT_W-1:0] cnt_r;

  assign qstat.full  = (cnt_r == ppndc_pkg::Q_CNT_W'(ppndc_pkg::Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

/* src/ppndc_back.sv */
// back part: bit-per-stage division, saturation and output register
`default_nettype none
module ppndc_back #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ppndc_pkg::q_stat_t  qstat,
  input  ppndc_pkg::entry_t   head,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0][31:0]    ndc,
  output logic                w_zero,
  output logic                saturated
);

  localparam int unsigned SAT_BITS = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic [32:0] POS_MAX  = (33'd1 << (SAT_BITS - 1)) - 33'd1;
  localparam logic [32:0] NEG_MAX  = 33'd1 << (SAT_BITS - 1);
  localparam int unsigned N        = ppndc_pkg::DIV_STEPS;

  ppndc_pkg::div_stage_t st_r [N+1];
  ppndc_pkg::div_stage_t st0_nxt;
  logic be;
  logic out_valid_r, sat_r, wz_r;
  logic [2:0][31:0] ndc_r, ndc_nxt;
  logic sat_nxt;
  logic [32:0] q;

  // pipeline moves whenever the output register is free or being drained
  assign be  = !out_valid_r || out_ready;
  assign pop = be && !qstat.empty;

  // entry stage: load remainder with the high half, flag quotients of 2^32 or more
  always_comb begin
    st0_nxt.valid  = !qstat.empty;
    st0_nxt.neg    = head.neg;
    st0_nxt.w_zero = head.w_zero;
    st0_nxt.den    = head.den;
    for (int l = 0; l < 3; l++) begin
      st0_nxt.lane[l].rem = ppndc_pkg::DEN_W'(head.mag[l][63:32]);
      st0_nxt.lane[l].lo  = head.mag[l][31:0];
      st0_nxt.lane[l].ovf = (ppndc_pkg::DEN_W'(head.mag[l][63:32]) >= head.den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  st_r[0].valid <= 1'b0;
    else if (be) st_r[0].valid <= st0_nxt.valid;
    if (be) begin
      st_r[0].neg    <= st0_nxt.neg;
      st_r[0].w_zero <= st0_nxt.w_zero;
      st_r[0].den    <= st0_nxt.den;
      st_r[0].lane   <= st0_nxt.lane;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_div
    ppndc_pkg::div_stage_t nxt;
    always_comb begin
      logic [ppndc_pkg::DEN_W:0] t;
      logic ge;
      nxt = st_r[k];
      for (int l = 0; l < 3; l++) begin
        t  = {st_r[k].lane[l].rem, st_r[k].lane[l].lo[31]};
        ge = (t >= {1'b0, st_r[k].den});
        nxt.lane[l].rem = ge ? ppndc_pkg::DEN_W'(t - {1'b0, st_r[k].den})
                             : t[ppndc_pkg::DEN_W-1:0];
        nxt.lane[l].lo  = {st_r[k].lane[l].lo[30:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n)  st_r[k+1].valid <= 1'b0;
      else if (be) st_r[k+1].valid <= nxt.valid;
      if (be) begin
        st_r[k+1].neg    <= nxt.neg;
        st_r[k+1].w_zero <= nxt.w_zero;
        st_r[k+1].den    <= nxt.den;
        st_r[k+1].lane   <= nxt.lane;
      end
    end
  end

  // sign, clamp and zero-w override
  always_comb begin
    sat_nxt = 1'b0;
    ndc_nxt = '0;
    q       = '0;
    for (int l = 0; l < 3; l++) begin
      q = {1'b0, st_r[N].lane[l].lo};
      if (st_r[N].neg[l]) begin
        if (st_r[N].lane[l].ovf || q > NEG_MAX) begin
          q = NEG_MAX;
          sat_nxt = 1'b1;
        end
        ndc_nxt[l] = 32'd0 - q[31:0];
      end else begin
        if (st_r[N].lane[l].ovf || q > POS_MAX) begin
          q = POS_MAX;
          sat_nxt = 1'b1;
        end
        ndc_nxt[l] = q[31:0];
      end
    end
    if (st_r[N].w_zero) begin
      ndc_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (be) out_valid_r <= st_r[N].valid;
    if (be) begin
      ndc_r <= ndc_nxt;
      sat_r <= sat_nxt;
      wz_r  <= st_r[N].w_zero;
    end
  end

  assign out_valid = out_valid_r;
  assign ndc       = ndc_r;
  assign saturated = sat_r;
  assign w_zero    = wz_r;

endmodule
`default_nettype wire

/* src/perspective_project_ndc.sv */
// top level: configuration registers, front, queue and back parts
// path: front stages, queue, entry stage, division stages, output register
// throughput: one point per cycle while the output is not stalled; the 32-stage divider takes one quotient bit a stage
// a stalled output holds the whole back part; the 4-entry queue lets the front keep going
// reset: synchronous active-low; clears control state, coefficients return to identity
// projection values (scales 1.0, depth scale -1.0, offsets and bias 0)
`default_nettype none
module perspective_project_ndc #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [95:0]  in_tdata,   // point_x, point_y, point_z
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,  // ndc_x, ndc_y, ndc_z
  output logic [1:0]  out_tuser,  // w_zero, saturated
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [31:0]  cfg_data
);

  ppndc_pkg::coef_t coef_r;
  ppndc_pkg::q_stat_t qstat;
  ppndc_pkg::entry_t push_data, head;
  logic push, pop, w_zero, saturated;
  logic [2:0][31:0] ndc;

  assign cfg_ready = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[ppndc_pkg::REG_X_SCALE]     <= 32'h0100_0000;
      coef_r[ppndc_pkg::REG_X_OFFSET]    <= 32'h0000_0000;
      coef_r[ppndc_pkg::REG_Y_SCALE]     <= 32'h0100_0000;
      coef_r[ppndc_pkg::REG_Y_OFFSET]    <= 32'h0000_0000;
      coef_r[ppndc_pkg::REG_DEPTH_SCALE] <= 32'hFF00_0000;
      coef_r[ppndc_pkg::REG_DEPTH_BIAS]  <= 32'h0000_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppndc_pkg::REG_X_SCALE:     coef_r[ppndc_pkg::REG_X_SCALE]     <= cfg_data;
        ppndc_pkg::REG_X_OFFSET:    coef_r[ppndc_pkg::REG_X_OFFSET]    <= cfg_data;
        ppndc_pkg::REG_Y_SCALE:     coef_r[ppndc_pkg::REG_Y_SCALE]     <= cfg_data;
        ppndc_pkg::REG_Y_OFFSET:    coef_r[ppndc_pkg::REG_Y_OFFSET]    <= cfg_data;
        ppndc_pkg::REG_DEPTH_SCALE: coef_r[ppndc_pkg::REG_DEPTH_SCALE] <= cfg_data;
        ppndc_pkg::REG_DEPTH_BIAS:  coef_r[ppndc_pkg::REG_DEPTH_BIAS]  <= cfg_data;
        default: ;
      endcase
    end
  end

  ppndc_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .px        (in_tdata[31:0]),
    .py        (in_tdata[63:32]),
    .pz        (in_tdata[95:64]),
    .coef      (coef_r),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  ppndc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ppndc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ndc       (ndc),
    .w_zero    (w_zero),
    .saturated (saturated)
  );

  assign out_tdata = {ndc[2], ndc[1], ndc[0]};
  assign out_tuser = {saturated, w_zero};

`ifndef ASSERT_OFF
  // zero w gives zero coordinates
  a_wzero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 96'd0))
    else $error("ndc not zero with zero w");
  // zero w never reports a clamp
  a_wzero_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tuser[1])
    else $error("saturation flagged with zero w");
  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  // queue never written while full
  a_queue_safe: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("queue overflow");
`endif

endmodule
`default_nettype wire
